// ===== rtl/imm_pkg.sv =====
// Package for the integer matrix multiply block: sizes, command and register
// codes, controller states, the command/status structs and the dimension clamp.
// No dependencies.
package imm_pkg;

    localparam int MAX_DIM = 8;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int DIM_W   = 4;
    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WR_A    = 2'd0,
        OP_WR_B    = 2'd1,
        OP_COMPUTE = 2'd2
    } imm_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_ROWS    = 2'd0,
        CFG_INNER_DIM = 2'd1,
        CFG_B_COLS    = 2'd2
    } imm_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } imm_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic             a_we;
        logic             b_we;
        logic             issue;
        logic             issue_last;
        logic [IDX_W-1:0] row_sel;
        logic [IDX_W-1:0] col_sel;
        logic [IDX_W-1:0] k_sel;
        logic             clear_acc;
        logic             set_done;
        logic             load_out;
        logic             out_last;
    } imm_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic acc_done;
        logic out_free;
    } imm_stat_t;

    // Saturate a dimension register to MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(MAX_DIM);
        return (v > lim) ? lim : v;
    endfunction

endpackage

// ===== rtl/imm_ctrl.sv =====
// Controller for the integer matrix multiply block: dimension registers,
// input decode and the sequencer over rows, columns and the inner index.
// Depends on imm_pkg.
module imm_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [imm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [imm_pkg::OP_W-1:0]       cmd,
    input  logic [imm_pkg::IDX_W-1:0]      row_index,
    input  logic [imm_pkg::IDX_W-1:0]      col_index,
    input  imm_pkg::imm_stat_t             stat,
    output imm_pkg::imm_cmd_t              dp_cmd
);
    import imm_pkg::*;

    imm_state_t       state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [DIM_W-1:0] a_rows_reg, inner_reg, b_cols_reg;
    logic [DIM_W-1:0] nr, nk, nc;
    logic             k_last, j_last, i_last, entry_last;

    assign nr = clamp_dim(a_rows_reg);
    assign nk = clamp_dim(inner_reg);
    assign nc = clamp_dim(b_cols_reg);

    assign k_last     = ({1'b0, k_reg} == (nk - DIM_W'(1)));
    assign j_last     = ({1'b0, j_reg} == (nc - DIM_W'(1)));
    assign i_last     = ({1'b0, i_reg} == (nr - DIM_W'(1)));
    assign entry_last = i_last && j_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= DIM_W'(MAX_DIM);
            inner_reg  <= DIM_W'(MAX_DIM);
            b_cols_reg <= DIM_W'(MAX_DIM);
        end
        else if (cfg_we)
        begin
            case (imm_cfg_t'(cfg_index))
                CFG_A_ROWS:    a_rows_reg <= cfg_data;
                CFG_INNER_DIM: inner_reg  <= cfg_data;
                CFG_B_COLS:    b_cols_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        in_stall       = (state_reg != ST_IDLE);
        dp_cmd         = '0;
        dp_cmd.row_sel = i_reg;
        dp_cmd.col_sel = j_reg;
        dp_cmd.k_sel   = k_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (imm_op_t'(cmd))
                        OP_WR_A:
                            dp_cmd.a_we = ({1'b0, row_index} < nr) && ({1'b0, col_index} < nk);
                        OP_WR_B:
                            dp_cmd.b_we = ({1'b0, row_index} < nk) && ({1'b0, col_index} < nc);
                        OP_COMPUTE:
                        begin
                            if ((nr != '0) && (nc != '0))
                            begin
                                i_next           = '0;
                                j_next           = '0;
                                k_next           = '0;
                                dp_cmd.clear_acc = 1'b1;
                                if (nk == '0)
                                begin
                                    dp_cmd.set_done = 1'b1;
                                    state_next      = ST_WAIT;
                                end
                                else
                                begin
                                    state_next = ST_RUN;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_RUN:
            begin
                dp_cmd.issue      = 1'b1;
                dp_cmd.issue_last = k_last;
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end

            ST_WAIT:
            begin
                if (stat.acc_done && stat.out_free)
                begin
                    dp_cmd.load_out = 1'b1;
                    dp_cmd.out_last = entry_last;
                    if (entry_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (j_last)
                        begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                        end
                        else
                        begin
                            j_next = j_reg + IDX_W'(1);
                        end
                        k_next           = '0;
                        dp_cmd.clear_acc = 1'b1;
                        if (nk == '0)
                        begin
                            dp_cmd.set_done = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_RUN;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_write_during_issue: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.issue |-> !(dp_cmd.a_we || dp_cmd.b_we))
        else $error("store write during product issue");

    a_load_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load_out |-> (stat.acc_done && stat.out_free))
        else $error("output load without a finished sum or free output");
`endif

endmodule

// ===== rtl/imm_datapath.sv =====
// Datapath for the integer matrix multiply block: A and B stores with valid
// bits, registered reads, multiplier, accumulator and output register.
// Depends on imm_pkg.
module imm_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  imm_pkg::imm_cmd_t             dp_cmd,
    output imm_pkg::imm_stat_t            stat,
    input  logic [imm_pkg::IDX_W-1:0]     row_index,
    input  logic [imm_pkg::IDX_W-1:0]     col_index,
    input  logic signed [imm_pkg::DATA_W-1:0] elem_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [imm_pkg::IDX_W-1:0]     out_row,
    output logic [imm_pkg::IDX_W-1:0]     out_col,
    output logic signed [imm_pkg::DATA_W-1:0] prod_value,
    output logic                          last_flag
);
    import imm_pkg::*;

    logic [DATA_W-1:0] a_mem [DEPTH];
    logic [DATA_W-1:0] b_mem [DEPTH];
    logic [DEPTH-1:0]  a_vld_reg, b_vld_reg;

    logic [ADDR_W-1:0] wr_addr, a_raddr, b_raddr;
    logic [DATA_W-1:0] a_rd_reg, b_rd_reg;
    logic              a_rd_vld_reg, b_rd_vld_reg;
    logic              s1_vld_reg, s1_last_reg;
    logic [DATA_W-1:0] a_q, b_q, prod_next, prod_reg;
    logic              s2_vld_reg, s2_last_reg;
    logic [DATA_W-1:0] acc_reg;
    logic              acc_done_reg;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_row_reg, out_col_reg;
    logic [DATA_W-1:0] out_val_reg;
    logic              out_last_reg;

    assign wr_addr = {row_index, col_index};
    assign a_raddr = {dp_cmd.row_sel, dp_cmd.k_sel};
    assign b_raddr = {dp_cmd.k_sel, dp_cmd.col_sel};

    always_ff @(posedge clk)
    begin
        if (dp_cmd.a_we)
        begin
            a_mem[wr_addr] <= elem_value;
        end
        if (dp_cmd.b_we)
        begin
            b_mem[wr_addr] <= elem_value;
        end
        a_rd_reg <= a_mem[a_raddr];
        b_rd_reg <= b_mem[b_raddr];
    end

    // Unwritten entries read as zero.
    assign a_q       = a_rd_vld_reg ? a_rd_reg : '0;
    assign b_q       = b_rd_vld_reg ? b_rd_reg : '0;
    assign prod_next = DATA_W'(a_q * b_q);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg    <= '0;
            b_vld_reg    <= '0;
            a_rd_vld_reg <= 1'b0;
            b_rd_vld_reg <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s2_last_reg  <= 1'b0;
        end
        else
        begin
            if (dp_cmd.a_we)
            begin
                a_vld_reg[wr_addr] <= 1'b1;
            end
            if (dp_cmd.b_we)
            begin
                b_vld_reg[wr_addr] <= 1'b1;
            end
            a_rd_vld_reg <= a_vld_reg[a_raddr];
            b_rd_vld_reg <= b_vld_reg[b_raddr];
            s1_vld_reg   <= dp_cmd.issue;
            s1_last_reg  <= dp_cmd.issue_last;
            s2_vld_reg   <= s1_vld_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            acc_done_reg <= 1'b0;
        end
        else if (dp_cmd.clear_acc)
        begin
            acc_reg      <= '0;
            acc_done_reg <= dp_cmd.set_done;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
            if (s2_last_reg)
            begin
                acc_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp_cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_out)
        begin
            out_row_reg  <= dp_cmd.row_sel;
            out_col_reg  <= dp_cmd.col_sel;
            out_val_reg  <= acc_reg;
            out_last_reg <= dp_cmd.out_last;
        end
    end

    assign stat.acc_done = acc_done_reg;
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign prod_value = out_val_reg;
    assign last_flag  = out_last_reg;

`ifndef SYNTHESIS
    a_clear_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.clear_acc |-> (!s1_vld_reg && !s2_vld_reg))
        else $error("accumulator cleared with products in flight");
`endif

endmodule

// ===== rtl/integer_matrix_multiply.sv =====
// Top level of the integer matrix multiply block: controller plus datapath.
// Depends on imm_pkg, imm_ctrl and imm_datapath.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   config  | cfg_we                | cfg_index, cfg_data (a_rows, inner_dim,
//           |                       | b_cols)
//   input   | in_valid / in_stall   | cmd, row_index, col_index, elem_value
//   output  | out_valid / out_stall | out_row, out_col, prod_value, last_flag
//
// A write of A or B goes straight into the store. A compute with R rows, C columns and
// inner dimension K works through the R * C entries of C one by one: K issues, two
// pipeline stages and one output load per entry (only the load when K is zero).
// The input stalls for the whole compute; an output stall holds the next load, and a
// held last result does not block writes. The shared multiplier sets the rate.
// Reset clears the store valid bits at once, so both matrices read as zero.
module integer_matrix_multiply (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [imm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [imm_pkg::OP_W-1:0]           cmd,
    input  logic [imm_pkg::IDX_W-1:0]          row_index,
    input  logic [imm_pkg::IDX_W-1:0]          col_index,
    input  logic signed [imm_pkg::DATA_W-1:0]  elem_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [imm_pkg::IDX_W-1:0]          out_row,
    output logic [imm_pkg::IDX_W-1:0]          out_col,
    output logic signed [imm_pkg::DATA_W-1:0]  prod_value,
    output logic                               last_flag
);
    import imm_pkg::*;

    imm_cmd_t  dp_cmd;
    imm_stat_t stat;

    // Sequencer: decode transfers, step i/j/k, hand out commands.
    imm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .row_index (row_index),
        .col_index (col_index),
        .stat      (stat),
        .dp_cmd    (dp_cmd)
    );

    // Stores, multiply-accumulate pipeline and output register.
    imm_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .stat       (stat),
        .row_index  (row_index),
        .col_index  (col_index),
        .elem_value (elem_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_row    (out_row),
        .out_col    (out_col),
        .prod_value (prod_value),
        .last_flag  (last_flag)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for integer_matrix_multiply: a directed script, then random
// load/compute batches under three idling mixes, checked against a local matrix model.
// Depends on imm_pkg and the integer_matrix_multiply RTL.
module tb_top;
    import imm_pkg::*;

    // cmd 3 has no package name; the block must ignore it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 30;
    localparam int SCRIPT_LEN = 32;

    // One expected entry of C
    typedef struct {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              last;
    } c_entry_t;

    // One line of the directed script: either a register write or an input transfer
    typedef struct {
        bit                is_cfg;
        imm_cfg_t          reg_sel;
        logic [DIM_W-1:0]  reg_val;
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  r;
        logic [IDX_W-1:0]  c;
        logic [DATA_W-1:0] v;
        bit                typed;
        logic [DATA_W-1:0] typed_val;
    } script_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [DIM_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [OP_W-1:0]           cmd;
    logic [IDX_W-1:0]          row_index;
    logic [IDX_W-1:0]          col_index;
    logic signed [DATA_W-1:0]  elem_value;
    logic                      out_valid;
    logic                      out_stall;
    logic [IDX_W-1:0]          out_row;
    logic [IDX_W-1:0]          out_col;
    logic signed [DATA_W-1:0]  prod_value;
    logic                      last_flag;

    // Local copy of the block: both stores and the three dimension registers
    logic [DATA_W-1:0] a_mem [DEPTH];
    logic [DATA_W-1:0] b_mem [DEPTH];
    logic [DIM_W-1:0]  dim_rows;
    logic [DIM_W-1:0]  dim_inner;
    logic [DIM_W-1:0]  dim_cols;

    c_entry_t    pending_c [$];
    script_row_t script [SCRIPT_LEN];

    int  errors;
    int  items_sent;
    int  effective_items;
    int  computes_sent;
    int  results_seen;
    int  send_idle;
    int  recv_stall;
    bit  hold_long;

    integer_matrix_multiply u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .row_index  (row_index),
        .col_index  (col_index),
        .elem_value (elem_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_row    (out_row),
        .out_col    (out_col),
        .prod_value (prod_value),
        .last_flag  (last_flag)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        $display("MISMATCH at %0t: %s got %0h want %0h", $time, what, got, want);
        errors++;
    endtask

    // A register above MAX_DIM acts as MAX_DIM
    function automatic int fit_dim(logic [DIM_W-1:0] d);
        return (d > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    // Apply one accepted transfer to the local stores; a compute queues every C entry
    function automatic void apply_matrix_op(logic [OP_W-1:0] op, logic [IDX_W-1:0] r,
                                            logic [IDX_W-1:0] c, logic [DATA_W-1:0] v);
        int nr;
        int nk;
        int nc;
        int n;
        logic [DATA_W-1:0] acc;
        c_entry_t e;
        nr = fit_dim(dim_rows);
        nk = fit_dim(dim_inner);
        nc = fit_dim(dim_cols);
        case (op)
            OP_WR_A:
            begin
                if (r < nr && c < nk)
                begin
                    a_mem[ADDR_W'(r * MAX_DIM + c)] = v;
                    effective_items++;
                end
            end
            OP_WR_B:
            begin
                if (r < nk && c < nc)
                begin
                    b_mem[ADDR_W'(r * MAX_DIM + c)] = v;
                    effective_items++;
                end
            end
            OP_COMPUTE:
            begin
                effective_items++;
                n = 0;
                for (int i = 0; i < nr; i++)
                begin
                    for (int j = 0; j < nc; j++)
                    begin
                        acc = '0;
                        // 32-bit operands keep only the low word of each product
                        for (int k = 0; k < nk; k++)
                            acc = acc + a_mem[ADDR_W'(i * MAX_DIM + k)]
                                      * b_mem[ADDR_W'(k * MAX_DIM + j)];
                        n++;
                        e.row   = IDX_W'(i);
                        e.col   = IDX_W'(j);
                        e.value = acc;
                        e.last  = (n == nr * nc);
                        pending_c.push_back(e);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Offer one input transfer, hold it until accepted, then update the model.
    // A typed row queues its single hand-written C entry instead of the computed one.
    task automatic send_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                             logic [DATA_W-1:0] v, bit typed, logic [DATA_W-1:0] typed_val);
        c_entry_t e;
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        row_index  <= r;
        col_index  <= c;
        elem_value <= v;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (op == OP_COMPUTE)
            computes_sent++;
        if (typed)
        begin
            e.row   = '0;
            e.col   = '0;
            e.value = typed_val;
            e.last  = 1'b1;
            pending_c.push_back(e);
            effective_items++;
        end
        else
        begin
            apply_matrix_op(op, r, c, v);
        end
    endtask

    // Drop valid and wait until every queued C entry has arrived, then let the block settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_c.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one dimension register; only called while the block is idle
    task automatic write_dim(imm_cfg_t sel, logic [DIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (sel)
            CFG_A_ROWS:    dim_rows  = val;
            CFG_INNER_DIM: dim_inner = val;
            CFG_B_COLS:    dim_cols  = val;
            default: ;
        endcase
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 15) - 8;
            3:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // Mostly small sizes keep computes short; eight and saturating values now and then
    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            8:       return DIM_W'(MAX_DIM);
            9:       return DIM_W'($urandom_range(MAX_DIM + 1, 15));
            default: return DIM_W'($urandom_range(1, 4));
        endcase
    endfunction

    // Write a random A or B entry; wild picks any index, so some land out of range
    task automatic random_write(bit wild);
        logic [OP_W-1:0] op;
        int lim_r;
        int lim_c;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        op = $urandom_range(0, 1) ? OP_WR_B : OP_WR_A;
        lim_r = (op == OP_WR_A) ? fit_dim(dim_rows) : fit_dim(dim_inner);
        lim_c = (op == OP_WR_A) ? fit_dim(dim_inner) : fit_dim(dim_cols);
        if (wild || lim_r == 0 || lim_c == 0)
        begin
            r = IDX_W'($urandom_range(0, MAX_DIM - 1));
            c = IDX_W'($urandom_range(0, MAX_DIM - 1));
        end
        else
        begin
            r = IDX_W'($urandom_range(0, lim_r - 1));
            c = IDX_W'($urandom_range(0, lim_c - 1));
        end
        send_item(op, r, c, pick_value(), 1'b0, '0);
    endtask

    // Result side: check every accepted C entry against the oldest expectation,
    // then choose the stall for the next cycle. A long hold request from the
    // stimulus overrides the random stall until its hold count runs out.
    initial
    begin : result_monitor
        int hold_left;
        c_entry_t e;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_c.size() == 0)
                begin
                    report_mismatch("unexpected C entry, row/col",
                                    DATA_W'({out_row, out_col}), '0);
                end
                else
                begin
                    e = pending_c.pop_front();
                    if (out_row !== e.row)
                        report_mismatch("out_row", DATA_W'(out_row), DATA_W'(e.row));
                    if (out_col !== e.col)
                        report_mismatch("out_col", DATA_W'(out_col), DATA_W'(e.col));
                    if (prod_value !== e.value)
                        report_mismatch("prod_value", prod_value, e.value);
                    if (last_flag !== e.last)
                        report_mismatch("last_flag", DATA_W'(last_flag), DATA_W'(e.last));
                end
            end
            if (hold_long)
            begin
                hold_left = LONG_HOLD_CYCLES;
                hold_long = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_stall);
            end
        end
    end

    // Give up if the run hangs
    initial
    begin : watchdog
        #2_000_000;
        $display("Timeout waiting for the block at %0t", $time);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        int start_eff;
        int nw;
        int roll;
        bit paused;

        // Drive every input to a known value before the first edge
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_A_ROWS;
        cfg_data   = '0;
        in_valid   = 1'b0;
        cmd        = OP_WR_A;
        row_index  = '0;
        col_index  = '0;
        elem_value = '0;
        hold_long  = 1'b0;
        send_idle  = 0;
        recv_stall = 0;
        errors          = 0;
        items_sent      = 0;
        effective_items = 0;
        computes_sent   = 0;
        results_seen    = 0;
        foreach (a_mem[i])
        begin
            a_mem[i] = '0;
            b_mem[i] = '0;
        end
        dim_rows  = DIM_W'(8);
        dim_inner = DIM_W'(8);
        dim_cols  = DIM_W'(8);

        // Directed script. Typed rows are 1x1 results readable at a glance:
        // max positive squared wraps to 1, min negative times -1 stays min negative.
        script = '{
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b0, 32'h0},
            '{1'b1, CFG_A_ROWS,    4'd1,  OP_WR_A,    3'd0, 3'd0, 32'h0,         1'b0, 32'h0},
            '{1'b1, CFG_INNER_DIM, 4'd1,  OP_WR_A,    3'd0, 3'd0, 32'h0,         1'b0, 32'h0},
            '{1'b1, CFG_B_COLS,    4'd1,  OP_WR_A,    3'd0, 3'd0, 32'h0,         1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_WR_A,    3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_WR_B,    3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b1, 32'h1},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_WR_A,    3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_WR_B,    3'd0, 3'd0, 32'hFFFF_FFFF, 1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_COMPUTE, 3'd0, 3'd0, 32'h0,   1'b1, 32'h8000_0000},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_WR_A,    3'd1, 3'd0, 32'h5,         1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_WR_B,    3'd0, 3'd7, 32'h5,         1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_UNUSED,  3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_COMPUTE, 3'd0, 3'd0, 32'h0,   1'b1, 32'h8000_0000},
            '{1'b1, CFG_INNER_DIM, 4'd0,  OP_WR_A,    3'd0, 3'd0, 32'h0,         1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b1, 32'h0},
            '{1'b1, CFG_A_ROWS,    4'd0,  OP_WR_A,    3'd0, 3'd0, 32'h0,         1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b0, 32'h0},
            '{1'b1, CFG_A_ROWS,    4'd15, OP_WR_A,    3'd0, 3'd0, 32'h0,         1'b0, 32'h0},
            '{1'b1, CFG_INNER_DIM, 4'd15, OP_WR_A,    3'd0, 3'd0, 32'h0,         1'b0, 32'h0},
            '{1'b1, CFG_B_COLS,    4'd15, OP_WR_A,    3'd0, 3'd0, 32'h0,         1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_WR_A,    3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_WR_B,    3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b0, 32'h0},
            '{1'b1, CFG_A_ROWS,    4'd3,  OP_WR_A,    3'd0, 3'd0, 32'h0,         1'b0, 32'h0},
            '{1'b1, CFG_INNER_DIM, 4'd2,  OP_WR_A,    3'd0, 3'd0, 32'h0,         1'b0, 32'h0},
            '{1'b1, CFG_B_COLS,    4'd2,  OP_WR_A,    3'd0, 3'd0, 32'h0,         1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_WR_A,    3'd2, 3'd1, 32'h0001_0000, 1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_WR_B,    3'd1, 3'd1, 32'h0001_0000, 1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b0, 32'h0},
            '{1'b1, CFG_B_COLS,    4'd0,  OP_WR_A,    3'd0, 3'd0, 32'h0,         1'b0, 32'h0},
            '{1'b0, CFG_A_ROWS,    4'd0,  OP_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b0, 32'h0}
        };

        // Hold reset, then release it away from the rising edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Walk the script; drain before any register write so the block is idle
        send_idle  = 10;
        recv_stall = 46;
        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                drain_results();
                write_dim(script[i].reg_sel, script[i].reg_val);
            end
            else
            begin
                send_item(script[i].op, script[i].r, script[i].c, script[i].v,
                          script[i].typed, script[i].typed_val);
            end
        end

        // Random part: three phases with the idling mix swapped, then switched off.
        // Each batch loads a few entries and computes, so most traffic is well formed.
        for (int phase = 0; phase < 3; phase++)
        begin
            drain_results();
            case (phase)
                0:
                begin
                    send_idle  = 10;
                    recv_stall = 46;
                end
                1:
                begin
                    send_idle  = 46;
                    recv_stall = 10;
                end
                default:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
            endcase
            if (phase == 2)
            begin
                // Full-size C with a short inner loop; the long output hold
                // backs the block up until it stalls the input side
                write_dim(CFG_A_ROWS, DIM_W'(MAX_DIM));
                write_dim(CFG_INNER_DIM, DIM_W'(3));
                write_dim(CFG_B_COLS, DIM_W'(MAX_DIM));
                hold_long = 1'b1;
            end
            else
            begin
                write_dim(CFG_A_ROWS, pick_dim());
                write_dim(CFG_INNER_DIM, pick_dim());
                write_dim(CFG_B_COLS, pick_dim());
            end
            start_eff = effective_items;
            paused = 1'b0;
            while (effective_items - start_eff < PHASE_ITEMS)
            begin
                nw = $urandom_range(1, 6);
                for (int w = 0; w < nw; w++)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 6)
                        send_item(OP_UNUSED, IDX_W'($urandom_range(0, 7)),
                                  IDX_W'($urandom_range(0, 7)), pick_value(), 1'b0, '0);
                    else
                        random_write(roll < 16);
                end
                send_item(OP_COMPUTE, IDX_W'($urandom_range(0, 7)),
                          IDX_W'($urandom_range(0, 7)), pick_value(), 1'b0, '0);
                // Pause the sender once per phase until every result is back
                if (!paused && effective_items - start_eff >= PHASE_ITEMS / 2)
                begin
                    paused = 1'b1;
                    drain_results();
                end
            end
        end

        drain_results();

        $display("Covered %0d input transfers (%0d computes) and %0d result transfers",
                 items_sent, computes_sent, results_seen);
        $display("Dimensions swept from zero through saturation under three stall mixes");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
